@@ design/pms_pkg.sv @@
// shared types, widths and codes for the point moment statistics block
// no dependencies; imported by every module of the block

package pms_pkg;

    localparam int COORD_W        = 24;
    localparam int CNT_W          = 11;
    localparam int SUM_W          = 34;
    localparam int PROD_W         = 48;
    localparam int SQ_W           = 58;
    localparam int SPREAD_W       = 23;
    localparam int COV_W          = 48;
    localparam int STAT_W         = 2;
    localparam int ROOT_W         = SQ_W / 2;
    localparam int REM_W          = 11;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int MIN_POINTS_RST = 1;

    // set queue between accumulator front and arithmetic back
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = 1;
    localparam int QLVL_W         = 2;

    // sequencing of the back end
    localparam int NUM_DIVS       = 5;
    localparam int NUM_MULS       = 3;
    localparam int NUM_SQRTS      = 2;
    localparam int SEL_W          = 3;
    localparam int STEP_W         = 6;
    localparam int DIV_STEPS      = SQ_W;
    localparam int SQRT_STEPS     = ROOT_W;

    // indexes into the working value array
    localparam int IDX_SX         = 0;
    localparam int IDX_SY         = 1;
    localparam int IDX_SXX        = 2;
    localparam int IDX_SYY        = 3;
    localparam int IDX_SXY        = 4;

    // configuration port
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam logic [ADDR_W-3:0] REG_MIN_POINTS = '0;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_DROP = 2'd2
    } status_t;

    // one closed set of points as handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             ovf;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]  sum_xx;
        logic [SQ_W-1:0]  sum_yy;
        logic [SQ_W-1:0]  sum_xy;
    } pms_set_t;

    // queue status seen by both sides
    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } pms_qstat_t;

endpackage

@@ design/pms_front.sv @@
// accumulator front end: takes one point per cycle while not full, keeps count and sums
// depends on pms_pkg; pushes each closed set into pms_queue

module pms_front #(
    parameter int MAX_POINTS = pms_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [pms_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pms_pkg::COORD_W-1:0]  y_coord,
    input  logic                                last_point,
    input  pms_pkg::pms_qstat_t                 q_stat,
    output logic                                q_push,
    output pms_pkg::pms_set_t                   q_entry
);
    import pms_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [CNT_W-1:0]   s1_cnt_reg;
    logic               s1_ovf_reg;

    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [COORD_W-1:0] s2_y_reg;
    logic [PROD_W-1:0]  s2_xx_reg;
    logic [PROD_W-1:0]  s2_yy_reg;
    logic [PROD_W-1:0]  s2_xy_reg;
    logic [CNT_W-1:0]   s2_cnt_reg;
    logic               s2_ovf_reg;

    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [SQ_W-1:0]    sum_xx_reg;
    logic [SQ_W-1:0]    sum_yy_reg;
    logic [SQ_W-1:0]    sum_xy_reg;

    logic               accept;
    logic               take;
    logic [CNT_W-1:0]   cnt_after;
    logic               ovf_after;
    logic [QLVL_W:0]    reserved;

    logic [SUM_W-1:0]   sum_x_next;
    logic [SUM_W-1:0]   sum_y_next;
    logic [SQ_W-1:0]    sum_xx_next;
    logic [SQ_W-1:0]    sum_yy_next;
    logic [SQ_W-1:0]    sum_xy_next;
    logic [PROD_W-1:0]  xx_prod;
    logic [PROD_W-1:0]  yy_prod;
    logic [PROD_W-1:0]  xy_prod;

    // every set still in the pipe needs a queue slot when it closes
    assign reserved = {1'b0, q_stat.level}
                    + (QLVL_W+1)'(s1_valid_reg & s1_last_reg)
                    + (QLVL_W+1)'(s2_valid_reg & s2_last_reg);
    assign full     = (reserved >= (QLVL_W+1)'(QDEPTH));
    assign accept   = push & ~full;

    assign take      = (count_reg < MAX_CNT);
    assign cnt_after = take ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_after = ovf_reg | ~take;

    assign xx_prod = $signed(s1_x_reg) * $signed(s1_x_reg);
    assign yy_prod = $signed(s1_y_reg) * $signed(s1_y_reg);
    assign xy_prod = $signed(s1_x_reg) * $signed(s1_y_reg);

    assign sum_x_next  = sum_x_reg
                       + {{(SUM_W-COORD_W){s2_x_reg[COORD_W-1]}}, s2_x_reg};
    assign sum_y_next  = sum_y_reg
                       + {{(SUM_W-COORD_W){s2_y_reg[COORD_W-1]}}, s2_y_reg};
    assign sum_xx_next = sum_xx_reg
                       + {{(SQ_W-PROD_W){s2_xx_reg[PROD_W-1]}}, s2_xx_reg};
    assign sum_yy_next = sum_yy_reg
                       + {{(SQ_W-PROD_W){s2_yy_reg[PROD_W-1]}}, s2_yy_reg};
    assign sum_xy_next = sum_xy_reg
                       + {{(SQ_W-PROD_W){s2_xy_reg[PROD_W-1]}}, s2_xy_reg};

    assign q_push         = s2_valid_reg & s2_last_reg;
    assign q_entry.cnt    = s2_cnt_reg;
    assign q_entry.ovf    = s2_ovf_reg;
    assign q_entry.sum_x  = sum_x_next;
    assign q_entry.sum_y  = sum_y_next;
    assign q_entry.sum_xx = sum_xx_next;
    assign q_entry.sum_yy = sum_yy_next;
    assign q_entry.sum_xy = sum_xy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_xx_reg   <= '0;
            sum_yy_reg   <= '0;
            sum_xy_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                if (last_point)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    count_reg <= cnt_after;
                    ovf_reg   <= ovf_after;
                end
            end
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    sum_x_reg  <= '0;
                    sum_y_reg  <= '0;
                    sum_xx_reg <= '0;
                    sum_yy_reg <= '0;
                    sum_xy_reg <= '0;
                end
                else
                begin
                    sum_x_reg  <= sum_x_next;
                    sum_y_reg  <= sum_y_next;
                    sum_xx_reg <= sum_xx_next;
                    sum_yy_reg <= sum_yy_next;
                    sum_xy_reg <= sum_xy_next;
                end
            end
        end
    end

    // pipeline payload; a dropped point travels as zero
    always_ff @(posedge clk)
    begin
        s1_last_reg <= last_point;
        s1_x_reg    <= take ? x_coord : '0;
        s1_y_reg    <= take ? y_coord : '0;
        s1_cnt_reg  <= cnt_after;
        s1_ovf_reg  <= ovf_after;

        s2_last_reg <= s1_last_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_xx_reg   <= xx_prod;
        s2_yy_reg   <= yy_prod;
        s2_xy_reg   <= xy_prod;
        s2_cnt_reg  <= s1_cnt_reg;
        s2_ovf_reg  <= s1_ovf_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("point count beyond set limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !(q_stat.level == QLVL_W'(QDEPTH)))
        else $error("set closed with no queue slot reserved");

endmodule

@@ design/pms_queue.sv @@
// short queue of closed sets between the accumulator front and the back end
// depends on pms_pkg

module pms_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  pms_pkg::pms_set_t    wr_data,
    input  logic                 rd_en,
    output pms_pkg::pms_set_t    rd_data,
    output pms_pkg::pms_qstat_t  stat
);
    import pms_pkg::*;

    pms_set_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (wr_en && !rd_en)
                level_reg <= level_reg + QLVL_W'(1);
            else if (rd_en && !wr_en)
                level_reg <= level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> level_reg != '0)
        else $error("set queue read while empty");

endmodule

@@ design/pms_back.sv @@
// arithmetic back end: divides the sums by the count, forms the variances
// and covariance, takes square roots and holds the result transaction
// depends on pms_pkg; reads closed sets from pms_queue

module pms_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pms_pkg::pms_qstat_t                  q_stat,
    input  pms_pkg::pms_set_t                    q_entry,
    output logic                                 q_pop,
    input  logic [pms_pkg::CNT_W-1:0]            min_points,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pms_pkg::STAT_W-1:0]           status,
    output logic [pms_pkg::CNT_W-1:0]            point_count,
    output logic signed [pms_pkg::COORD_W-1:0]   mean_x,
    output logic signed [pms_pkg::COORD_W-1:0]   mean_y,
    output logic [pms_pkg::SPREAD_W-1:0]         spread_x,
    output logic [pms_pkg::SPREAD_W-1:0]         spread_y,
    output logic signed [pms_pkg::COV_W-1:0]     covariance
);
    import pms_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DLOAD  = 10'b00_0000_0010,
        S_DIV    = 10'b00_0000_0100,
        S_DSTORE = 10'b00_0000_1000,
        S_MUL    = 10'b00_0001_0000,
        S_SUB    = 10'b00_0010_0000,
        S_SLOAD  = 10'b00_0100_0000,
        S_SQRT   = 10'b00_1000_0000,
        S_SSTORE = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SEL_W-1:0]   sel_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               out_valid_reg;

    logic [SQ_W-1:0]    w_val [NUM_DIVS];
    logic [CNT_W-1:0]   w_cnt_reg;
    logic               w_ovf_reg;
    logic               w_few_reg;

    logic [SQ_W-1:0]    dv_mag_reg;
    logic               dv_neg_reg;
    logic [REM_W-1:0]   dv_rem_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SQ_W-1:0]    sq_val_reg;
    logic [ROOT_W+1:0]  sq_rem_reg;
    logic [ROOT_W-1:0]  sq_root_reg;
    logic [SPREAD_W-1:0] sp_x_reg;
    logic [SPREAD_W-1:0] sp_y_reg;

    logic [STAT_W-1:0]  status_reg;
    logic [CNT_W-1:0]   point_count_reg;
    logic [COORD_W-1:0] mean_x_reg;
    logic [COORD_W-1:0] mean_y_reg;
    logic [SPREAD_W-1:0] spread_x_reg;
    logic [SPREAD_W-1:0] spread_y_reg;
    logic [COV_W-1:0]   covariance_reg;

    logic               few;
    logic               out_free;
    logic [SQ_W-1:0]    cur_val;
    logic [SEL_W-1:0]   upper_idx;
    logic [SQ_W-1:0]    upper_val;
    logic [REM_W:0]     dv_shift;
    logic               dv_ge;
    logic [COORD_W-1:0] mul_a;
    logic [COORD_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [ROOT_W+3:0]  sq_shift;
    logic [ROOT_W+3:0]  sq_trial;
    logic               sq_ge;
    logic [SPREAD_W-1:0] root_sat;
    logic [SQ_W-1:0]    cov_full;
    logic               cov_fits;
    logic [COV_W-1:0]   cov_sat;

    assign few      = (q_entry.cnt == '0) || (q_entry.cnt < min_points);
    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;
    assign out_free = !out_valid_reg || pop;

    assign cur_val   = w_val[sel_reg];
    assign upper_idx = sel_reg + SEL_W'(IDX_SXX);
    assign upper_val = w_val[upper_idx];

    // restoring divide by the point count, one quotient bit per cycle
    assign dv_shift = {dv_rem_reg, dv_mag_reg[SQ_W-1]};
    assign dv_ge    = (dv_shift >= {1'b0, w_cnt_reg});

    always_comb
    begin
        case (sel_reg)
            SEL_W'(0):
            begin
                mul_a = w_val[IDX_SX][COORD_W-1:0];
                mul_b = w_val[IDX_SX][COORD_W-1:0];
            end
            SEL_W'(1):
            begin
                mul_a = w_val[IDX_SY][COORD_W-1:0];
                mul_b = w_val[IDX_SY][COORD_W-1:0];
            end
            default:
            begin
                mul_a = w_val[IDX_SX][COORD_W-1:0];
                mul_b = w_val[IDX_SY][COORD_W-1:0];
            end
        endcase
    end

    assign mul_p = $signed(mul_a) * $signed(mul_b);

    // digit-by-digit square root, two radicand bits per cycle
    assign sq_shift = {sq_rem_reg, sq_val_reg[SQ_W-1 -: 2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    assign root_sat = (|sq_root_reg[ROOT_W-1:SPREAD_W]) ? '1
                                                       : sq_root_reg[SPREAD_W-1:0];

    assign cov_full = w_val[IDX_SXY];
    assign cov_fits = (&cov_full[SQ_W-1:COV_W-1]) || !(|cov_full[SQ_W-1:COV_W-1]);
    assign cov_sat  = cov_fits ? cov_full[COV_W-1:0]
                    : (cov_full[SQ_W-1] ? {1'b1, {(COV_W-1){1'b0}}}
                                        : {1'b0, {(COV_W-1){1'b1}}});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!q_stat.empty)
                    state_next = few ? S_OUT : S_DLOAD;
            S_DLOAD:
                state_next = S_DIV;
            S_DIV:
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_DSTORE;
            S_DSTORE:
                state_next = (sel_reg == SEL_W'(NUM_DIVS - 1)) ? S_MUL : S_DLOAD;
            S_MUL:
                state_next = S_SUB;
            S_SUB:
                state_next = (sel_reg == SEL_W'(NUM_MULS - 1)) ? S_SLOAD : S_MUL;
            S_SLOAD:
                state_next = S_SQRT;
            S_SQRT:
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = S_SSTORE;
            S_SSTORE:
                state_next = (sel_reg == SEL_W'(NUM_SQRTS - 1)) ? S_OUT : S_SLOAD;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:   sel_reg <= '0;
                S_DSTORE: sel_reg <= (sel_reg == SEL_W'(NUM_DIVS - 1)) ? '0
                                                                      : sel_reg + SEL_W'(1);
                S_SUB:    sel_reg <= (sel_reg == SEL_W'(NUM_MULS - 1)) ? '0
                                                                      : sel_reg + SEL_W'(1);
                S_SSTORE: sel_reg <= sel_reg + SEL_W'(1);
                default:  sel_reg <= sel_reg;
            endcase
            if (state_reg == S_DLOAD || state_reg == S_SLOAD)
                step_reg <= '0;
            else if (state_reg == S_DIV || state_reg == S_SQRT)
                step_reg <= step_reg + STEP_W'(1);
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                w_val[IDX_SX]  <= {{(SQ_W-SUM_W){q_entry.sum_x[SUM_W-1]}}, q_entry.sum_x};
                w_val[IDX_SY]  <= {{(SQ_W-SUM_W){q_entry.sum_y[SUM_W-1]}}, q_entry.sum_y};
                w_val[IDX_SXX] <= q_entry.sum_xx;
                w_val[IDX_SYY] <= q_entry.sum_yy;
                w_val[IDX_SXY] <= q_entry.sum_xy;
                w_cnt_reg      <= q_entry.cnt;
                w_ovf_reg      <= q_entry.ovf;
                w_few_reg      <= few;
            end
            S_DLOAD:
            begin
                dv_neg_reg <= cur_val[SQ_W-1];
                dv_mag_reg <= cur_val[SQ_W-1] ? (~cur_val + SQ_W'(1)) : cur_val;
                dv_rem_reg <= '0;
            end
            S_DIV:
            begin
                dv_mag_reg <= {dv_mag_reg[SQ_W-2:0], dv_ge};
                dv_rem_reg <= dv_ge ? REM_W'(dv_shift - {1'b0, w_cnt_reg})
                                    : REM_W'(dv_shift);
            end
            S_DSTORE:
                w_val[sel_reg] <= dv_neg_reg ? (~dv_mag_reg + SQ_W'(1)) : dv_mag_reg;
            S_MUL:
                prod_reg <= mul_p;
            S_SUB:
                w_val[upper_idx] <= upper_val
                                  - {{(SQ_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            S_SLOAD:
            begin
                // truncation can leave a small negative variance; treat it as zero
                sq_val_reg  <= upper_val[SQ_W-1] ? '0 : upper_val;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_SQRT:
            begin
                sq_val_reg  <= {sq_val_reg[SQ_W-3:0], 2'b00};
                sq_rem_reg  <= sq_ge ? (ROOT_W+2)'(sq_shift - sq_trial)
                                     : (ROOT_W+2)'(sq_shift);
                sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
            end
            S_SSTORE:
            begin
                if (sel_reg == '0)
                    sp_x_reg <= root_sat;
                else
                    sp_y_reg <= root_sat;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    point_count_reg <= w_cnt_reg;
                    if (w_few_reg)
                    begin
                        status_reg     <= STAT_FEW;
                        mean_x_reg     <= '0;
                        mean_y_reg     <= '0;
                        spread_x_reg   <= '0;
                        spread_y_reg   <= '0;
                        covariance_reg <= '0;
                    end
                    else
                    begin
                        status_reg     <= w_ovf_reg ? STAT_DROP : STAT_OK;
                        mean_x_reg     <= w_val[IDX_SX][COORD_W-1:0];
                        mean_y_reg     <= w_val[IDX_SY][COORD_W-1:0];
                        spread_x_reg   <= sp_x_reg;
                        spread_y_reg   <= sp_y_reg;
                        covariance_reg <= cov_sat;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty       = !out_valid_reg;
    assign status      = status_reg;
    assign point_count = point_count_reg;
    assign mean_x      = mean_x_reg;
    assign mean_y      = mean_y_reg;
    assign spread_x    = spread_x_reg;
    assign spread_y    = spread_y_reg;
    assign covariance  = covariance_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(covariance_reg))
        else $error("waiting result transaction lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_DLOAD) || (state_reg == S_OUT))
        else $error("set taken from queue without starting work");

endmodule

@@ design/point_moment_statistics.sv @@
// point_moment_statistics: top level; uses pms_pkg, pms_front, pms_queue and
// pms_back. Points enter one per cycle through push/full and are summed in a
// three-stage accumulator (register, multiply, add); a marked last point
// closes the set and hands its count and sums to a two-entry queue. The back
// end then works through one set at a time with a shared bit-serial divider
// (five divides), one 24x24 multiplier and a two-bit-per-cycle square root
// (two roots); a set with too few points skips the arithmetic and goes straight
// to posting its result. The front keeps accepting points while the back works
// and stalls only when both queue entries are taken or claimed by closed sets
// still in the accumulator pipe.
// min_points sits at byte address 0 of the configuration port.

module point_moment_statistics #(
    parameter int MAX_POINTS = pms_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pms_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [pms_pkg::COORD_W-1:0]   y_coord,
    input  logic                                 last_point,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pms_pkg::STAT_W-1:0]           status,
    output logic [pms_pkg::CNT_W-1:0]            point_count,
    output logic signed [pms_pkg::COORD_W-1:0]   mean_x,
    output logic signed [pms_pkg::COORD_W-1:0]   mean_y,
    output logic [pms_pkg::SPREAD_W-1:0]         spread_x,
    output logic [pms_pkg::SPREAD_W-1:0]         spread_y,
    output logic signed [pms_pkg::COV_W-1:0]     covariance,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pms_pkg::ADDR_W-1:0]           paddr,
    input  logic [pms_pkg::DATA_W-1:0]           pwdata,
    output logic [pms_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import pms_pkg::*;

    logic [CNT_W-1:0] min_points_reg;
    logic             reg_hit;
    pms_qstat_t       q_stat;
    pms_set_t         q_wr_data;
    pms_set_t         q_rd_data;
    logic             q_push;
    logic             q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_MIN_POINTS);
    assign prdata  = reg_hit ? {{(DATA_W-CNT_W){1'b0}}, min_points_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_points_reg <= CNT_W'(MIN_POINTS_RST);
        else if (psel && penable && pwrite && pready && reg_hit)
            min_points_reg <= pwdata[CNT_W-1:0];
    end

    pms_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .last_point (last_point),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_entry    (q_wr_data)
    );

    pms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    pms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_entry     (q_rd_data),
        .q_pop       (q_pop),
        .min_points  (min_points_reg),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .point_count (point_count),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .spread_x    (spread_x),
        .spread_y    (spread_y),
        .covariance  (covariance)
    );

endmodule
